// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the box filter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BF3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box filter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BF3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box filter check failed");

`endif

// ===== sv/bf3_pkg.sv =====
// ---------------------------------------------------------------------------
// bf3_pkg
// Widths, constants, types and helpers shared by the 3x3 box filter.
// ---------------------------------------------------------------------------
package bf3_pkg;

    // Frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int WIN_SKIP   = 2;

    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);
    localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

    // Datapath widths
    localparam int SAMPLE_W  = 16;
    localparam int COLSUM_W  = SAMPLE_W + 2;
    localparam int WINSUM_W  = SAMPLE_W + 4;
    localparam int MEAN_W    = 20;
    localparam int NUM_CELLS = 2;

    // Mean: floor((16*sum + 4) / 9), biased positive by 9*2^19 and
    // divided by reciprocal multiply
    localparam int DIV_U_W    = 24;
    localparam int DIV_R_W    = 25;
    localparam int DIV_SHIFT  = 28;
    localparam int PROD_W     = DIV_U_W + DIV_R_W;
    localparam logic [DIV_U_W-1:0] DIV_BIAS  = DIV_U_W'(9 * (1 << 19));
    localparam logic [DIV_R_W-1:0] DIV_RECIP = DIV_R_W'(29826162);

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    // One line store word: rows r-2 and r-1 at one column
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] top;
        logic signed [SAMPLE_W-1:0] mid;
    } pair_t;

    // Per-beat tag carried down the pipe
    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } tag_t;

    // Last valid position: the dimension register clamped to 3..hi, minus one
    function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] d;
        if (v < DIM_MIN)
            d = DIM_MIN;
        else if (v > hi)
            d = hi;
        else
            d = v;
        return d - DIM_W'(1);
    endfunction

endpackage

// ===== sv/bf3_if.sv =====
// ---------------------------------------------------------------------------
// bf3_if
// Valid/ready stream interfaces for samples in and block means out.
// ---------------------------------------------------------------------------
interface bf3_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bf3_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bf3_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bf3_pkg::MEAN_W-1:0]    block_mean;
    logic                                 row_end;
    logic                                 frame_end;

    modport source (output valid, output block_mean, output row_end,
                    output frame_end, input ready);
    modport sink   (input valid, input block_mean, input row_end,
                    input frame_end, output ready);
endinterface

// ===== sv/bf3_line_store.sv =====
// ---------------------------------------------------------------------------
// bf3_line_store
// Two-row line store, one word per column, registered read, with a
// zeroing sweep after reset.
// ---------------------------------------------------------------------------
module bf3_line_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [bf3_pkg::COL_W-1:0]     rd_addr,
    output bf3_pkg::pair_t                rd_data,
    input  logic                          wr_en,
    input  logic [bf3_pkg::COL_W-1:0]     wr_addr,
    input  bf3_pkg::pair_t                wr_data,
    output logic                          busy
);

    bf3_pkg::pair_t                mem [bf3_pkg::MAX_WIDTH];
    bf3_pkg::pair_t                rd_data_reg;
    logic                          clr_busy_reg;
    logic [bf3_pkg::COL_W-1:0]     clr_cnt_reg;
    logic                          mem_we;
    logic [bf3_pkg::COL_W-1:0]     mem_wa;
    bf3_pkg::pair_t                mem_wd;

    // Clearing sweep: one word per cycle from address zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == bf3_pkg::COL_W'(bf3_pkg::MAX_WIDTH - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // Write port shared between the sweep and normal traffic
    always_comb
    begin
        mem_we = clr_busy_reg || wr_en;
        mem_wa = clr_busy_reg ? clr_cnt_reg : wr_addr;
        mem_wd = clr_busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

// ===== sv/bf3_col_cell.sv =====
// ---------------------------------------------------------------------------
// bf3_col_cell
// One window column cell: holds a column sum, hands it on when the window
// shifts, and adds it into the running window total.
// ---------------------------------------------------------------------------
module bf3_col_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 shift,
    input  logic signed [bf3_pkg::COLSUM_W-1:0]  sum_in,
    output logic signed [bf3_pkg::COLSUM_W-1:0]  sum_out,
    input  logic signed [bf3_pkg::WINSUM_W-1:0]  acc_in,
    output logic signed [bf3_pkg::WINSUM_W-1:0]  acc_out
);

    logic signed [bf3_pkg::COLSUM_W-1:0] sum_reg;

    // Column held until the next window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (shift)
            sum_reg <= sum_in;
    end

    // Running total along the chain
    assign acc_out = acc_in
                   + {{(bf3_pkg::WINSUM_W - bf3_pkg::COLSUM_W){sum_reg[bf3_pkg::COLSUM_W-1]}},
                      sum_reg};
    assign sum_out = sum_reg;

endmodule

// ===== sv/bf3_mean_div.sv =====
// ---------------------------------------------------------------------------
// bf3_mean_div
// Window sum to mean x16, rounded half up, via a biased reciprocal
// multiply by 1/9.
// ---------------------------------------------------------------------------
module bf3_mean_div (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic signed [bf3_pkg::WINSUM_W-1:0]  sum,
    output logic signed [bf3_pkg::MEAN_W-1:0]    mean
);

    logic [bf3_pkg::DIV_U_W-1:0] u;
    logic [bf3_pkg::PROD_W-1:0]  prod_next;
    logic [bf3_pkg::PROD_W-1:0]  prod_reg;
    logic [bf3_pkg::MEAN_W-1:0]  q;

    // floor((32*sum+9)/18) == floor((16*sum+4)/9); bias keeps it positive
    assign u         = {sum, 4'b0100} + bf3_pkg::DIV_BIAS;
    assign prod_next = bf3_pkg::PROD_W'(u) * bf3_pkg::PROD_W'(bf3_pkg::DIV_RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= prod_next;
    end

    // Removing the bias quotient 2^19 flips the top bit
    assign q    = prod_reg[bf3_pkg::DIV_SHIFT +: bf3_pkg::MEAN_W];
    assign mean = {~q[bf3_pkg::MEAN_W-1], q[bf3_pkg::MEAN_W-2:0]};

endmodule

// ===== sv/box_filter_3x3_average.sv =====
// ---------------------------------------------------------------------------
// box_filter_3x3_average
// 3x3 box filter, valid region only, mean x16 rounded half up.
// ---------------------------------------------------------------------------
// Usage:
//   pixel_in  : one signed 16-bit sample per beat, raster order.
//   mean_out  : one beat per fully covered 3x3 block, (H-2) x (W-2) per
//               frame, with row_end / frame_end on the last mean of a row /
//               of the frame.
//   APB port  : frame_width at 0x0, frame_height at 0x4 (11 bits, clamped
//               to 3..1024 in use); write only while the filter is idle.
// Throughput: one sample per cycle unless the reset sweep or a full pipe
//   holds pixel_in.ready low; the line store has one read and one write
//   port and the column cells shift once per sample.
// Stages: line store read, window sum, reciprocal multiply, output reg.
// Reset: positions go to zero, registers to 1024; the line store is then
//   zeroed word by word with pixel_in.ready low.
// Stall: a held mean sits in the output register while the stages behind
//   it keep filling; pixel_in.ready drops only once every stage is full.
// ---------------------------------------------------------------------------
module box_filter_3x3_average (
    input  logic                          clk,
    input  logic                          rst_n,
    bf3_in_if.sink                        pixel_in,
    bf3_out_if.source                     mean_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bf3_pkg::ADDR_W-1:0]    paddr,
    input  logic [bf3_pkg::DATA_W-1:0]    pwdata,
    output logic [bf3_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // Configuration
    logic [bf3_pkg::DIM_W-1:0]   width_reg;
    logic [bf3_pkg::DIM_W-1:0]   height_reg;
    logic                        cfg_wr;
    bf3_pkg::reg_idx_t           cfg_idx;
    logic [bf3_pkg::DIM_W-1:0]   w_last;
    logic [bf3_pkg::DIM_W-1:0]   h_last;

    // Position
    logic [bf3_pkg::COL_W-1:0]   col_reg;
    logic [bf3_pkg::ROW_W-1:0]   row_reg;
    logic                        col_wrap;
    logic                        row_wrap;
    logic                        in_acc;
    bf3_pkg::tag_t               tag_now;

    // Stage A: line store read
    logic                                a_valid_reg;
    logic signed [bf3_pkg::SAMPLE_W-1:0] a_sample_reg;
    bf3_pkg::tag_t                       a_tag_reg;
    logic [bf3_pkg::COL_W-1:0]           a_addr_reg;
    logic                                a_go;
    bf3_pkg::pair_t                      rd_pair;
    bf3_pkg::pair_t                      wr_pair;
    logic                                clr_busy;

    // Column chain
    logic signed [bf3_pkg::COLSUM_W-1:0] col_sum;
    logic signed [bf3_pkg::COLSUM_W-1:0] cell_sum [bf3_pkg::NUM_CELLS+1];
    logic signed [bf3_pkg::WINSUM_W-1:0] cell_acc [bf3_pkg::NUM_CELLS+1];

    // Stage B: window sum
    logic                                b_valid_reg;
    logic signed [bf3_pkg::WINSUM_W-1:0] b_sum_reg;
    bf3_pkg::tag_t                       b_tag_reg;
    logic                                b_free;
    logic                                b_go;

    // Stage C: product
    logic                                c_valid_reg;
    bf3_pkg::tag_t                       c_tag_reg;
    logic                                c_free;
    logic                                c_go;
    logic signed [bf3_pkg::MEAN_W-1:0]   c_mean;

    // Output register
    logic                                o_valid_reg;
    logic signed [bf3_pkg::MEAN_W-1:0]   o_mean_reg;
    logic                                o_row_end_reg;
    logic                                o_frame_end_reg;
    logic                                o_free;

    // APB register writes
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = bf3_pkg::reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bf3_pkg::DIM_RESET;
            height_reg <= bf3_pkg::DIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                bf3_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[bf3_pkg::DIM_W-1:0];
                bf3_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[bf3_pkg::DIM_W-1:0];
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // APB readback
    always_comb
    begin
        unique case (cfg_idx)
            bf3_pkg::REG_FRAME_WIDTH:
                prdata = {{(bf3_pkg::DATA_W - bf3_pkg::DIM_W){1'b0}}, width_reg};
            bf3_pkg::REG_FRAME_HEIGHT:
                prdata = {{(bf3_pkg::DATA_W - bf3_pkg::DIM_W){1'b0}}, height_reg};
            default:
                prdata = '0;
        endcase
    end

    // Clamped limits
    assign w_last = bf3_pkg::dim_last(width_reg, bf3_pkg::DIM_MAX_W);
    assign h_last = bf3_pkg::dim_last(height_reg, bf3_pkg::DIM_MAX_H);

    // Raster position and per-beat flags
    assign in_acc   = pixel_in.valid && pixel_in.ready;
    assign col_wrap = bf3_pkg::DIM_W'(col_reg) >= w_last;
    assign row_wrap = bf3_pkg::DIM_W'(row_reg) >= h_last;

    always_comb
    begin
        tag_now.emit      = (row_reg >= bf3_pkg::ROW_W'(bf3_pkg::WIN_SKIP))
                         && (col_reg >= bf3_pkg::COL_W'(bf3_pkg::WIN_SKIP));
        tag_now.row_end   = bf3_pkg::DIM_W'(col_reg) == w_last;
        tag_now.frame_end = tag_now.row_end && (bf3_pkg::DIM_W'(row_reg) == h_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Handshake chain, output side first
    assign o_free = !o_valid_reg || mean_out.ready;
    assign c_go   = c_valid_reg && o_free;
    assign c_free = !c_valid_reg || o_free;
    assign b_go   = b_valid_reg && c_free;
    assign b_free = !b_valid_reg || c_free;
    assign a_go   = a_valid_reg && (!a_tag_reg.emit || b_free);

    assign pixel_in.ready = !clr_busy && (!a_valid_reg || a_go);

    // Stage A
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_acc)
            a_valid_reg <= 1'b1;
        else if (a_go)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_sample_reg <= pixel_in.sample;
            a_tag_reg    <= tag_now;
            a_addr_reg   <= col_reg;
        end
    end

    // Rows shift up one place in the line store
    assign wr_pair.top = rd_pair.mid;
    assign wr_pair.mid = a_sample_reg;

    bf3_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (rd_pair),
        .wr_en   (a_go),
        .wr_addr (a_addr_reg),
        .wr_data (wr_pair),
        .busy    (clr_busy)
    );

    // Current column, then the chain of held columns
    assign col_sum =
          {{(bf3_pkg::COLSUM_W - bf3_pkg::SAMPLE_W){rd_pair.top[bf3_pkg::SAMPLE_W-1]}},
           rd_pair.top}
        + {{(bf3_pkg::COLSUM_W - bf3_pkg::SAMPLE_W){rd_pair.mid[bf3_pkg::SAMPLE_W-1]}},
           rd_pair.mid}
        + {{(bf3_pkg::COLSUM_W - bf3_pkg::SAMPLE_W){a_sample_reg[bf3_pkg::SAMPLE_W-1]}},
           a_sample_reg};

    assign cell_sum[0] = col_sum;
    assign cell_acc[0] = {{(bf3_pkg::WINSUM_W - bf3_pkg::COLSUM_W){col_sum[bf3_pkg::COLSUM_W-1]}},
                          col_sum};

    for (genvar i = 0; i < bf3_pkg::NUM_CELLS; i++)
    begin : g_cell
        bf3_col_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (a_go),
            .sum_in  (cell_sum[i]),
            .sum_out (cell_sum[i+1]),
            .acc_in  (cell_acc[i]),
            .acc_out (cell_acc[i+1])
        );
    end

    // Stage B
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (a_go && a_tag_reg.emit)
            b_valid_reg <= 1'b1;
        else if (b_go)
            b_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_go && a_tag_reg.emit)
        begin
            b_sum_reg <= cell_acc[bf3_pkg::NUM_CELLS];
            b_tag_reg <= a_tag_reg;
        end
    end

    // Stage C
    bf3_mean_div u_mean_div (
        .clk  (clk),
        .load (b_go),
        .sum  (b_sum_reg),
        .mean (c_mean)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (b_go)
            c_valid_reg <= 1'b1;
        else if (c_go)
            c_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
            c_tag_reg <= b_tag_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (c_go)
            o_valid_reg <= 1'b1;
        else if (mean_out.ready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (c_go)
        begin
            o_mean_reg      <= c_mean;
            o_row_end_reg   <= c_tag_reg.row_end;
            o_frame_end_reg <= c_tag_reg.frame_end;
        end
    end

    assign mean_out.valid      = o_valid_reg;
    assign mean_out.block_mean = o_mean_reg;
    assign mean_out.row_end    = o_row_end_reg;
    assign mean_out.frame_end  = o_frame_end_reg;

endmodule

// ===== sv/bf3_checker.sv =====
// ---------------------------------------------------------------------------
// bf3_checker
// Port-level checks on the box filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bf3_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bf3_pkg::MEAN_W-1:0]    block_mean,
    input  logic                          row_end,
    input  logic                          frame_end,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [bf3_pkg::ADDR_W-1:0]    paddr,
    input  logic [bf3_pkg::DATA_W-1:0]    pwdata,
    input  logic [bf3_pkg::DATA_W-1:0]    prdata
);

    logic [bf3_pkg::MEAN_W+1:0]  out_payload;
    logic                        cfg_wr;
    logic [bf3_pkg::DIM_W-1:0]   rd_low;
    logic [bf3_pkg::DIM_W-1:0]   wr_low;

    // Output payload and register write taps
    assign out_payload = {block_mean, row_end, frame_end};
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign rd_low      = prdata[bf3_pkg::DIM_W-1:0];
    assign wr_low      = pwdata[bf3_pkg::DIM_W-1:0];

    // Last mean of the frame is also the last of its row
    `BF3_ASSERT_NOW(a_frame_end_row_end, out_valid && frame_end, row_end)

    // Stalled beat stays offered
    `BF3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // Stalled beat keeps its payload
    `BF3_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload))

    // A register write reads back on the next cycle at the same address
    `BF3_ASSERT_NOW(a_cfg_readback, cfg_wr ##1 paddr == $past(paddr), rd_low == $past(wr_low))

endmodule

bind box_filter_3x3_average bf3_checker u_bf3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (mean_out.valid),
    .out_ready  (mean_out.ready),
    .block_mean (mean_out.block_mean),
    .row_end    (mean_out.row_end),
    .frame_end  (mean_out.frame_end),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 box filter. Samples are streamed in raster
// order through the valid/ready input, every accepted sample is run through
// a local model of the line stores and window, and each output beat is
// compared against the oldest predicted block mean. The frame geometry is
// changed over the APB port between bursts (in and out of range, mid-frame)
// and read back. Traffic runs with and without source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP = 100;

    // One predicted output beat
    typedef struct {
        logic signed [bf3_pkg::MEAN_W-1:0] mean;
        logic                              row_end;
        logic                              frame_end;
    } mean_beat_t;

    logic clk;
    logic rst_n;

    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [bf3_pkg::ADDR_W-1:0] paddr;
    logic [bf3_pkg::DATA_W-1:0] pwdata;
    logic [bf3_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    bf3_in_if  pix_if ();
    bf3_out_if mean_if ();

    // Filter model state
    logic signed [bf3_pkg::SAMPLE_W-1:0] line_mem [0:2*bf3_pkg::MAX_WIDTH-1];
    logic signed [bf3_pkg::SAMPLE_W-1:0] win_mem [0:5];
    logic [bf3_pkg::COL_W-1:0]           col_pos;
    logic [bf3_pkg::ROW_W-1:0]           row_pos;
    logic [bf3_pkg::DIM_W-1:0]           width_reg;
    logic [bf3_pkg::DIM_W-1:0]           height_reg;
    mean_beat_t                          pending_means [$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int samples_sent;
    int means_checked;
    int config_writes;
    int cycle_count;

    box_filter_3x3_average i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pix_if),
        .mean_out (mean_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d means outstanding", cycle_count,
                     pending_means.size());
            $display("box_filter_3x3_average verification failed");
            $finish;
        end
    end

    // Sink back-pressure
    always @(negedge clk)
    begin
        mean_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned clamp_dim(input logic [bf3_pkg::DIM_W-1:0] v,
                                              input int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    // Advance the model by one accepted sample; queue the mean it completes
    function automatic void filter_model_step(input logic signed [bf3_pkg::SAMPLE_W-1:0] s);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [bf3_pkg::COL_W:0] top_idx;
        logic [bf3_pkg::COL_W:0] mid_idx;
        logic signed [bf3_pkg::SAMPLE_W-1:0] top;
        logic signed [bf3_pkg::SAMPLE_W-1:0] mid;
        longint sum;
        longint num;
        longint q;
        mean_beat_t beat;

        w = clamp_dim(width_reg, bf3_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, bf3_pkg::MAX_HEIGHT);
        c = 32'(col_pos);
        r = 32'(row_pos);
        // row r-2 in the lower half, row r-1 in the upper half
        top_idx = {1'b0, col_pos};
        mid_idx = {1'b1, col_pos};
        top = line_mem[top_idx];
        mid = line_mem[mid_idx];

        if (r >= 2 && c >= 2)
        begin
            sum = longint'(top) + longint'(mid) + longint'(s);
            for (int k = 0; k < 6; k++)
                sum += longint'(win_mem[k]);
            // round half up of sum*16/9, floored division
            num = sum * 32 + 9;
            if (num >= 0)
                q = num / 18;
            else
                q = -((-num + 17) / 18);
            beat.mean = q[bf3_pkg::MEAN_W-1:0];
            beat.row_end = (c == w - 1);
            beat.frame_end = beat.row_end && (r == h - 1);
            pending_means.push_back(beat);
        end

        // shift the window by one column
        win_mem[0] = win_mem[3];
        win_mem[1] = win_mem[4];
        win_mem[2] = win_mem[5];
        win_mem[3] = top;
        win_mem[4] = mid;
        win_mem[5] = s;

        line_mem[top_idx] = mid;
        line_mem[mid_idx] = s;

        // positions beyond a shrunk limit wrap on the next advance
        if (c + 1 >= w)
        begin
            col_pos = '0;
            row_pos = (r + 1 >= h) ? '0 : bf3_pkg::ROW_W'(r + 1);
        end
        else
            col_pos = bf3_pkg::COL_W'(c + 1);
    endfunction

    function automatic logic signed [bf3_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return bf3_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    // Mostly small dimensions, now and then below range or clamped high
    function automatic logic [bf3_pkg::DATA_W-1:0] rand_dim();
        logic [bf3_pkg::DATA_W-1:0] v;
        v = $urandom();
        case ($urandom_range(15))
            0: v[bf3_pkg::DIM_W-1:0] = bf3_pkg::DIM_W'($urandom_range(2));
            1: v[bf3_pkg::DIM_W-1:0] = bf3_pkg::DIM_W'($urandom_range(1025, 2047));
            default: v[bf3_pkg::DIM_W-1:0] = bf3_pkg::DIM_W'($urandom_range(3, 10));
        endcase
        return v;
    endfunction

    // Send one sample beat; returns at the falling edge after acceptance
    task automatic send_sample(input logic signed [bf3_pkg::SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.sample <= s;
        do
            @(posedge clk);
        while (pix_if.ready !== 1'b1);
        filter_model_step(s);
        samples_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted mean has come out
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write followed by a readback of the same register
    task automatic write_config(input bf3_pkg::reg_idx_t idx,
                                input logic [bf3_pkg::DATA_W-1:0] data);
        logic [bf3_pkg::DATA_W-1:0] readback;

        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bf3_pkg::ADDR_W'(4 * int'(idx));
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx == bf3_pkg::REG_FRAME_WIDTH)
            width_reg = data[bf3_pkg::DIM_W-1:0];
        else
            height_reg = data[bf3_pkg::DIM_W-1:0];
        config_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        // the bus goes idle before the next transfer
        @(negedge clk);
        if (readback !== bf3_pkg::DATA_W'(data[bf3_pkg::DIM_W-1:0]))
            report_mismatch($sformatf("register %s read 0x%0h, wrote 0x%0h", idx.name(),
                                      readback, data));
    endtask

    // Output checker
    always @(posedge clk)
    begin : check_means
        mean_beat_t want;
        if (rst_n === 1'b1 && mean_if.valid === 1'b1 && mean_if.ready === 1'b1)
        begin
            if (pending_means.size() == 0)
                report_mismatch($sformatf("unexpected mean beat %0d", mean_if.block_mean));
            else
            begin
                want = pending_means.pop_front();
                means_checked++;
                if (mean_if.block_mean !== want.mean)
                    report_mismatch($sformatf("mean #%0d: got %0d want %0d", means_checked,
                                              mean_if.block_mean, want.mean));
                if (mean_if.row_end !== want.row_end)
                    report_mismatch($sformatf("mean #%0d: row_end got %b want %b",
                                              means_checked, mean_if.row_end, want.row_end));
                if (mean_if.frame_end !== want.frame_end)
                    report_mismatch($sformatf("mean #%0d: frame_end got %b want %b",
                                              means_checked, mean_if.frame_end,
                                              want.frame_end));
            end
        end
    end

    // Reset geometry (1024 wide): part of the first row, no means expected
    task automatic test_reset_geometry();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 100; i++)
            send_sample(rand_sample());
        drain();
    endtask

    // 3x3 frames: all max, all min, and a small negative sum
    task automatic test_directed_extremes();
        logic signed [bf3_pkg::SAMPLE_W-1:0] s;

        send_idle_pct = 24;
        recv_stall_pct = 24;
        write_config(bf3_pkg::REG_FRAME_WIDTH, 32'd3);
        write_config(bf3_pkg::REG_FRAME_HEIGHT, 32'd3);
        // positions left beyond the new limit: run on to the next frame start
        while (col_pos != 0 || row_pos != 0)
            send_sample(rand_sample());
        for (int f = 0; f < 3; f++)
        begin
            for (int k = 0; k < 9; k++)
            begin
                case (f)
                    0: s = 16'sh7FFF;
                    1: s = 16'sh8000;
                    default: s = (k == 0) ? -16'sd1 : 16'sd0;
                endcase
                send_sample(s);
            end
        end
        drain();
    endtask

    // Out of range and junk upper bits, written mid-frame
    task automatic test_register_clamp();
        logic [bf3_pkg::DATA_W-1:0] width_vals [6];
        logic [bf3_pkg::DATA_W-1:0] height_vals [6];

        width_vals = '{32'h0, 32'h1, 32'h7FF, 32'hFFFF_F804, 32'h0000_0402, 32'h2};
        height_vals = '{32'h7FF, 32'h2, 32'h5, 32'h5555_5003, 32'h0, 32'h400};
        for (int i = 0; i < 6; i++)
        begin
            write_config(bf3_pkg::REG_FRAME_WIDTH, width_vals[i]);
            write_config(bf3_pkg::REG_FRAME_HEIGHT, height_vals[i]);
            for (int k = 0; k < 25; k++)
                send_sample(rand_sample());
            drain();
        end
    endtask

    // Random bursts over the four idle/stall profiles
    task automatic test_random_traffic();
        int idle_set [4];
        int stall_set [4];

        idle_set = '{0, 76, 0, 24};
        stall_set = '{0, 0, 76, 24};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_set[p];
            recv_stall_pct = stall_set[p];
            for (int b = 0; b < 4; b++)
            begin
                write_config(bf3_pkg::REG_FRAME_WIDTH, rand_dim());
                write_config(bf3_pkg::REG_FRAME_HEIGHT, rand_dim());
                for (int k = 0; k < 30; k++)
                begin
                    send_sample(rand_sample());
                    // occasional hold-off until the output side is empty
                    if ($urandom_range(39) == 0)
                        drain();
                end
                drain();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_if.valid = 1'b0;
        pix_if.sample = '0;
        mean_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        samples_sent = 0;
        means_checked = 0;
        config_writes = 0;
        cycle_count = 0;

        // model reset
        width_reg = bf3_pkg::DIM_RESET;
        height_reg = bf3_pkg::DIM_RESET;
        col_pos = '0;
        row_pos = '0;
        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (win_mem[i])
            win_mem[i] = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_geometry();
        test_directed_extremes();
        test_register_clamp();
        test_random_traffic();

        drain();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("Streamed %0d samples, checked %0d block means, %0d register writes",
                 samples_sent, means_checked, config_writes);
        $display("Geometries from 3x3 to 1024 wide, clamped values, four idle/stall profiles");
        if (error_count == 0)
            $display("box_filter_3x3_average verification clean");
        else
            $display("box_filter_3x3_average verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bf3_pkg.sv
sv/bf3_if.sv
sv/bf3_line_store.sv
sv/bf3_col_cell.sv
sv/bf3_mean_div.sv
sv/box_filter_3x3_average.sv
sv/bf3_checker.sv
tb/sv/tb_top.sv
